### hw/rtl/utf8x_pkg.sv
package utf8x_pkg;

	localparam logic [7:0] Lead2Min = 8'hC2;
	localparam logic [7:0] Lead2Max = 8'hDF;
	localparam logic [7:0] Lead3Min = 8'hE0;
	localparam logic [7:0] Lead3Max = 8'hEF;
	localparam logic [7:0] Lead4Min = 8'hF0;
	localparam logic [7:0] Lead4Max = 8'hF4;
	localparam logic [7:0] ContMask = 8'hC0;
	localparam logic [7:0] ContTag = 8'h80;
	localparam logic [7:0] AsciiNul = 8'h00;
	localparam logic [7:0] AsciiTab = 8'h09;
	localparam logic [7:0] AsciiLf = 8'h0A;
	localparam logic [7:0] AsciiCr = 8'h0D;
	localparam logic [7:0] AsciiSpace = 8'h20;
	localparam logic [7:0] AsciiDel = 8'h7F;

	localparam logic [20:0] MaxCodePoint = 21'h10FFFF;
	localparam logic [20:0] SurrogateLow = 21'h00D800;
	localparam logic [20:0] SurrogateHigh = 21'h00DFFF;
	localparam logic [20:0] Min2Byte = 21'h000080;
	localparam logic [20:0] Min3Byte = 21'h000800;
	localparam logic [20:0] Min4Byte = 21'h010000;

	typedef logic [20:0] code_point_t;

	typedef enum logic [2:0] {
		SEQ_NONE  = 3'd0,
		SEQ_TWO   = 3'd2,
		SEQ_THREE = 3'd3,
		SEQ_FOUR  = 3'd4
	} seq_len_t;

	function automatic logic ascii_legal(input logic [7:0] b);
		logic ok;
		ok = (b >= AsciiSpace) || (b == AsciiTab) || (b == AsciiCr) || (b == AsciiLf);
		if (b == AsciiNul || b == AsciiDel) begin
			ok = 1'b0;
		end
		return ok;
	endfunction

	function automatic logic scalar_legal(input seq_len_t len, input code_point_t v);
		logic ok;
		ok = (v <= MaxCodePoint) && !(v >= SurrogateLow && v <= SurrogateHigh);
		case (len)
			SEQ_TWO: begin
				if (v < Min2Byte) ok = 1'b0;
			end
			SEQ_THREE: begin
				if (v < Min3Byte) ok = 1'b0;
			end
			SEQ_FOUR: begin
				if (v < Min4Byte) ok = 1'b0;
			end
			default: begin
			end
		endcase
		return ok;
	endfunction

endpackage

### hw/rtl/utf8_xml_char_validator.sv
// Streaming UTF-8 checker for XML character data. One byte is taken per beat on the
// input channel, with last_byte marking the end of a buffer, and exactly one result beat
// comes out for each input beat. An accepted byte is held in the byte register, and its
// result is written into the output register when the output is not stalled. A new byte
// can be accepted every cycle while the output is not stalled: the byte register feeds
// the decode logic, and its result is written into the output register together with
// the decoder state. char_done flags a completed legal character with its code_point,
// error_seen is sticky for the rest of the buffer, and buffer_valid gives the verdict on
// the final byte. The decoder state clears after each final byte.
module utf8_xml_char_validator
	import utf8x_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  byte_value,
	input  logic        last_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        char_done,
	output logic [20:0] code_point,
	output logic        error_seen,
	output logic        buffer_valid
);

	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        last_s1;

	logic        pend_zero;
	logic [1:0]  pend_q;
	seq_len_t    len_q;
	code_point_t part_q;
	logic        fail_q;

	logic [1:0]  pend_d;
	seq_len_t    len_d;
	code_point_t part_d;
	logic        fail_d;
	logic        done_d;
	code_point_t cp_d;
	code_point_t joined;

	logic        out_valid_q;
	logic        char_done_q;
	code_point_t code_point_q;
	logic        error_seen_q;
	logic        buffer_valid_q;

	logic out_load;
	logic advance;

	assign out_load = !out_valid_q || out_ready;
	assign advance  = valid_s1 && out_load;
	assign in_ready = !valid_s1 || out_load;

	assign pend_zero = (pend_q == 2'd0);
	assign joined = {part_q[14:0], byte_s1[5:0]};

	always_comb begin
		pend_d = pend_q;
		len_d  = len_q;
		part_d = part_q;
		fail_d = fail_q;
		done_d = 1'b0;
		cp_d   = '0;
		if (!fail_q) begin
			if (pend_zero) begin
				if (!byte_s1[7]) begin
					if (ascii_legal(byte_s1)) begin
						done_d = 1'b1;
						cp_d   = {13'd0, byte_s1};
					end else begin
						fail_d = 1'b1;
					end
				end else if (byte_s1 >= Lead2Min && byte_s1 <= Lead2Max) begin
					len_d  = SEQ_TWO;
					pend_d = 2'd1;
					part_d = {16'd0, byte_s1[4:0]};
				end else if (byte_s1 >= Lead3Min && byte_s1 <= Lead3Max) begin
					len_d  = SEQ_THREE;
					pend_d = 2'd2;
					part_d = {17'd0, byte_s1[3:0]};
				end else if (byte_s1 >= Lead4Min && byte_s1 <= Lead4Max) begin
					len_d  = SEQ_FOUR;
					pend_d = 2'd3;
					part_d = {18'd0, byte_s1[2:0]};
				end else begin
					fail_d = 1'b1;
				end
			end else if ((byte_s1 & ContMask) != ContTag) begin
				fail_d = 1'b1;
			end else begin
				pend_d = pend_q - 2'd1;
				part_d = joined;
				if (pend_q == 2'd1) begin
					// Range checks are made once the whole sequence is in.
					if (scalar_legal(len_q, joined)) begin
						done_d = 1'b1;
						cp_d   = joined;
					end else begin
						fail_d = 1'b1;
					end
					len_d  = SEQ_NONE;
					part_d = '0;
				end
			end
		end
		// A sequence left open at the end of the buffer fails it.
		if (last_s1 && !fail_d && pend_d != 2'd0) begin
			fail_d = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= byte_value;
			last_s1 <= last_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= 2'd0;
			len_q  <= SEQ_NONE;
			part_q <= '0;
			fail_q <= 1'b0;
		end else if (advance) begin
			if (last_s1) begin
				pend_q <= 2'd0;
				len_q  <= SEQ_NONE;
				part_q <= '0;
				fail_q <= 1'b0;
			end else begin
				pend_q <= pend_d;
				len_q  <= len_d;
				part_q <= part_d;
				fail_q <= fail_d;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			char_done_q    <= done_d;
			code_point_q   <= cp_d;
			error_seen_q   <= fail_d;
			buffer_valid_q <= last_s1 && !fail_d;
		end
	end

	assign out_valid    = out_valid_q;
	assign char_done    = char_done_q;
	assign code_point   = code_point_q;
	assign error_seen   = error_seen_q;
	assign buffer_valid = buffer_valid_q;

endmodule

### hw/rtl/utf8x_checker.sv
module utf8x_checker
	import utf8x_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic        char_done,
	input logic [20:0] code_point,
	input logic        error_seen,
	input logic        buffer_valid
);

	// A finished character is always a legal scalar value.
	a_cp_legal: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && char_done |->
			code_point <= MaxCodePoint &&
			!(code_point >= SurrogateLow && code_point <= SurrogateHigh))
		else $error("decoded code point out of range or surrogate");

	// Once a buffer has failed no more characters are reported in it.
	a_done_no_err: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && char_done |-> !error_seen)
		else $error("character reported after an error");

	a_verdict: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && buffer_valid |-> !error_seen)
		else $error("buffer marked valid with an error");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=>
			out_valid && $stable(char_done) && $stable(code_point) &&
			$stable(error_seen) && $stable(buffer_valid))
		else $error("result beat changed while stalled");

	// An input beat that is offered and refused stays offered.
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_ready |=> in_valid)
		else $error("input beat withdrawn before acceptance");

endmodule

bind utf8_xml_char_validator utf8x_checker u_utf8x_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_valid),
	.in_ready     (in_ready),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.char_done    (char_done),
	.code_point   (code_point),
	.error_seen   (error_seen),
	.buffer_valid (buffer_valid)
);

### sim/testbench.sv
`timescale 1ns / 1ps

module testbench;
	import utf8x_pkg::*;

	typedef logic [7:0] byte_q_t[$];

	typedef struct {
		logic        done;
		code_point_t cp;
		logic        err;
		logic        verdict;
	} byte_verdict_t;

	localparam int IdleLimit = 600;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [7:0]  byte_value = 8'h00;
	logic        last_byte = 1'b0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic        char_done;
	logic [20:0] code_point;
	logic        error_seen;
	logic        buffer_valid;

	// Decoder state mirrored by the predictor.
	logic [1:0]  cont_left = 2'd0;
	seq_len_t    seq_len = SEQ_NONE;
	code_point_t gathered = '0;
	logic        buf_failed = 1'b0;

	byte_verdict_t pending_verdicts[$];
	int items_sent = 0;
	int mismatches = 0;
	int idle_cycles = 0;
	int stall_left = 0;
	bit calm = 1'b0;

	utf8_xml_char_validator uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.byte_value   (byte_value),
		.last_byte    (last_byte),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.char_done    (char_done),
		.code_point   (code_point),
		.error_seen   (error_seen),
		.buffer_valid (buffer_valid)
	);

	always #6 clk = ~clk;

	function automatic int pick_idle();
		int r;
		if (calm) return 0;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 93) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	task automatic decode_byte(input logic [7:0] b, input logic last);
		byte_verdict_t r;
		code_point_t floor_val;
		r = '{done: 1'b0, cp: '0, err: 1'b0, verdict: 1'b0};
		if (!buf_failed) begin
			if (cont_left == 2'd0) begin
				if (b < ContTag) begin
					if (b != AsciiNul && b != AsciiDel && (b >= AsciiSpace || b == AsciiTab ||
					    b == AsciiCr || b == AsciiLf)) begin
						r.done = 1'b1;
						r.cp = {13'd0, b};
					end else begin
						buf_failed = 1'b1;
					end
				end else if (b >= Lead2Min && b <= Lead2Max) begin
					seq_len = SEQ_TWO;
					cont_left = 2'd1;
					gathered = {16'd0, b[4:0]};
				end else if (b >= Lead3Min && b <= Lead3Max) begin
					seq_len = SEQ_THREE;
					cont_left = 2'd2;
					gathered = {17'd0, b[3:0]};
				end else if (b >= Lead4Min && b <= Lead4Max) begin
					seq_len = SEQ_FOUR;
					cont_left = 2'd3;
					gathered = {18'd0, b[2:0]};
				end else begin
					buf_failed = 1'b1;
				end
			end else if ((b & ContMask) != ContTag) begin
				buf_failed = 1'b1;
			end else begin
				gathered = {gathered[14:0], b[5:0]};
				cont_left = cont_left - 2'd1;
				if (cont_left == 2'd0) begin
					case (seq_len)
						SEQ_TWO: floor_val = Min2Byte;
						SEQ_THREE: floor_val = Min3Byte;
						default: floor_val = Min4Byte;
					endcase
					if (gathered < floor_val || gathered > MaxCodePoint ||
					    (gathered >= SurrogateLow && gathered <= SurrogateHigh)) begin
						buf_failed = 1'b1;
					end else begin
						r.done = 1'b1;
						r.cp = gathered;
					end
					seq_len = SEQ_NONE;
					gathered = '0;
				end
			end
		end
		// A sequence still open on the final byte fails the buffer.
		if (last && cont_left != 2'd0) buf_failed = 1'b1;
		r.err = buf_failed;
		if (last) begin
			r.verdict = !buf_failed;
			cont_left = 2'd0;
			seq_len = SEQ_NONE;
			gathered = '0;
			buf_failed = 1'b0;
		end
		pending_verdicts.push_back(r);
	endtask

	task automatic send_byte(input logic [7:0] b, input logic last);
		int gap;
		in_valid <= 1'b1;
		byte_value <= b;
		last_byte <= last;
		do @(posedge clk); while (!in_ready);
		decode_byte(b, last);
		items_sent++;
		gap = pick_idle();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic send_buffer(input byte_q_t bytes);
		foreach (bytes[i]) send_byte(bytes[i], i == bytes.size() - 1);
	endtask

	// Called right after a beat so that valid drops before a pause.
	task automatic idle_sender();
		in_valid <= 1'b0;
	endtask

	task automatic check_field(input string name, input int unsigned want, input int unsigned got);
		if (want != got) begin
			$display("%0t: %s expected 0x%0h, got 0x%0h", $time, name, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk) begin
		byte_verdict_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_verdicts.size() == 0) begin
				$display("%0t: unexpected result beat, expected none, got done=%0b cp=0x%0h err=%0b valid=%0b",
				         $time, char_done, code_point, error_seen, buffer_valid);
				mismatches++;
			end else begin
				want = pending_verdicts.pop_front();
				check_field("char_done", want.done, char_done);
				check_field("code_point", want.cp, code_point);
				check_field("error_seen", want.err, error_seen);
				check_field("buffer_valid", want.verdict, buffer_valid);
			end
		end
	end

	always @(posedge clk) begin
		int n;
		if (stall_left > 0) begin
			out_ready <= 1'b0;
			stall_left--;
		end else begin
			n = pick_idle();
			out_ready <= (n == 0);
			if (n > 0) stall_left = n - 1;
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IdleLimit) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	task automatic test_ascii_controls();
		byte_q_t seq;
		seq = '{AsciiTab, AsciiLf, AsciiCr, AsciiSpace, 8'h7E};
		send_buffer(seq);
		// Bytes after a failure are ignored until the buffer ends.
		seq = '{AsciiDel, 8'h41};
		send_buffer(seq);
		seq = '{AsciiNul};
		send_buffer(seq);
		seq = '{8'h1F};
		send_buffer(seq);
	endtask

	task automatic test_multibyte_limits();
		byte_q_t seq;
		seq = '{8'hC2, 8'h80, 8'hEF, 8'hBF, 8'hBF};
		send_buffer(seq);
		seq = '{8'hF4, 8'h8F, 8'hBF, 8'hBF};
		send_buffer(seq);
	endtask

	task automatic test_malformed();
		byte_q_t seq;
		seq = '{8'hE0, 8'h80, 8'h80};
		send_buffer(seq);
		seq = '{8'hED, 8'hA0, 8'h80};
		send_buffer(seq);
		seq = '{8'hF4, 8'h90, 8'h80, 8'h80};
		send_buffer(seq);
		seq = '{8'hC3, 8'h41};
		send_buffer(seq);
		seq = '{8'hFF};
		send_buffer(seq);
		seq = '{8'hF0, 8'h9F};
		send_buffer(seq);
	endtask

	// Stop in the middle of a sequence until every result is back, then finish it.
	task automatic test_drain_pause();
		send_byte(8'hE2, 1'b0);
		idle_sender();
		while (pending_verdicts.size() != 0) @(posedge clk);
		@(posedge clk);
		send_byte(8'h82, 1'b0);
		send_byte(8'hAC, 1'b1);
	endtask

	task automatic test_random_buffers(input int count);
		byte_q_t seq;
		int stop_at;
		int kind;
		int len;
		code_point_t cp;
		stop_at = items_sent + count;
		while (items_sent < stop_at) begin
			seq = {};
			calm = ($urandom_range(0, 9) == 0);
			if ($urandom_range(0, 19) == 0) begin
				repeat ($urandom_range(1, 8)) seq.push_back(8'($urandom_range(0, 255)));
			end else begin
				repeat ($urandom_range(1, 10)) begin
					kind = $urandom_range(0, 99);
					if (kind < 35) begin
						len = 1;
						if (kind < 3) cp = 21'($urandom_range(0, 127));
						else if (kind < 6) cp = {13'd0, AsciiLf};
						else cp = 21'($urandom_range(32, 126));
					end else if (kind < 55) begin
						len = 2;
						cp = 21'($urandom_range(32'h80, 32'h7FF));
					end else if (kind < 75) begin
						len = 3;
						cp = 21'($urandom_range(32'h800, 32'hFFFF));
					end else if (kind < 92) begin
						len = 4;
						cp = 21'($urandom_range(32'h10000, 32'h10FFFF));
					end else if (kind < 96) begin
						// Overlong: a value that fits a shorter form.
						len = $urandom_range(2, 4);
						case (len)
							2: cp = 21'($urandom_range(0, 32'h7F));
							3: cp = 21'($urandom_range(0, 32'h7FF));
							default: cp = 21'($urandom_range(0, 32'hFFFF));
						endcase
					end else begin
						len = 4;
						cp = 21'($urandom_range(32'h110000, 32'h1FFFFF));
					end
					case (len)
						1: seq.push_back(cp[7:0]);
						2: begin
							seq.push_back({3'b110, cp[10:6]});
							seq.push_back({2'b10, cp[5:0]});
						end
						3: begin
							seq.push_back({4'b1110, cp[15:12]});
							seq.push_back({2'b10, cp[11:6]});
							seq.push_back({2'b10, cp[5:0]});
						end
						default: begin
							seq.push_back({5'b11110, cp[20:18]});
							seq.push_back({2'b10, cp[17:12]});
							seq.push_back({2'b10, cp[11:6]});
							seq.push_back({2'b10, cp[5:0]});
						end
					endcase
				end
				if ($urandom_range(0, 9) == 0)
					seq[$urandom_range(0, seq.size() - 1)] = 8'($urandom_range(0, 255));
				if ($urandom_range(0, 11) == 0 && seq.size() > 1)
					void'(seq.pop_back());
			end
			send_buffer(seq);
		end
		calm = 1'b0;
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_ascii_controls();
		test_multibyte_limits();
		test_malformed();
		test_random_buffers(500);
		test_drain_pause();
		test_random_buffers(500);
		idle_sender();
		while (pending_verdicts.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (mismatches == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
